### hw/rtl/esip_pkg.sv
`timescale 1ns / 1ps
// shared types, widths, codes and microcode rom for the encoder speed pid block
// no dependencies
package esip_pkg;

    localparam int COUNT_W   = 16;
    localparam int FRAC_BITS = 8;

    localparam int SPEED_W = 24;
    localparam int GAIN_W  = 16;
    localparam int E_W     = SPEED_W + 1;
    localparam int DE_W    = E_W + 1;
    localparam int DDE_W   = DE_W + 1;
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = (COUNT_W > DDE_W) ? COUNT_W : DDE_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int INC_W   = SUM_W - FRAC_BITS;
    localparam int DUTY_W  = 8 + FRAC_BITS;
    localparam int ACC_W   = INC_W + 1;

    localparam int SPEED_MAX  = 8388607;
    localparam int SPEED_MIN  = -8388608;
    localparam int DUTY_TOP   = 255 << FRAC_BITS;
    localparam int DUTY_RESET = 100 << FRAC_BITS;

    localparam logic [1:0] CMD_EDGE_A = 2'd0;
    localparam logic [1:0] CMD_EDGE_B = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd4;

    localparam logic [2:0] MUL_NONE  = 3'd0;
    localparam logic [2:0] MUL_SPEED = 3'd1;
    localparam logic [2:0] MUL_KI    = 3'd2;
    localparam logic [2:0] MUL_KP    = 3'd3;
    localparam logic [2:0] MUL_KD    = 3'd4;

    localparam logic [1:0] BR_NEXT = 2'd0;
    localparam logic [1:0] BR_TICK = 2'd1;
    localparam logic [1:0] BR_DONE = 2'd2;

    localparam int PC_W = 4;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [GAIN_W-1:0]         kd;
        logic [GAIN_W-1:0]         scale;
    } cfg_t;

    typedef struct packed {
        logic            cnt_edge;
        logic [2:0]      mul_sel;
        logic            ld_speed;
        logic            ld_e;
        logic            ld_de;
        logic            ld_dde;
        logic            sum_load;
        logic            sum_add;
        logic            emit;
        logic [1:0]      branch;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '0;

    localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd0;
    localparam logic [PC_W-1:0] STEP_TICK     = 4'd1;

    function automatic ctrl_t esip_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (pc)
            4'd0:
            begin
                w.cnt_edge = 1'b1;
                w.branch   = BR_TICK;
                w.target   = STEP_TICK;
            end
            4'd1: w.mul_sel = MUL_SPEED;
            4'd2: w.ld_speed = 1'b1;
            4'd3: w.ld_e = 1'b1;
            4'd4:
            begin
                w.ld_de   = 1'b1;
                w.mul_sel = MUL_KI;
            end
            4'd5:
            begin
                w.ld_dde   = 1'b1;
                w.sum_load = 1'b1;
                w.mul_sel  = MUL_KP;
            end
            4'd6:
            begin
                w.sum_add = 1'b1;
                w.mul_sel = MUL_KD;
            end
            4'd7: w.sum_add = 1'b1;
            4'd8:
            begin
                w.emit   = 1'b1;
                w.branch = BR_DONE;
            end
            default: w.branch = BR_DONE;
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/esip_in_if.sv
`timescale 1ns / 1ps
// input item channel: encoder edge events and control ticks
// no dependencies
interface esip_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       level_a;
    logic       level_b;

    modport source (output valid, output command, output level_a, output level_b, input ready);
    modport sink (input valid, input command, input level_a, input level_b, output ready);
endinterface

### hw/rtl/esip_out_if.sv
`timescale 1ns / 1ps
// result item channel: measured speed and pwm duty
// depends on esip_pkg
interface esip_out_if;
    import esip_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_rpm;
    logic [7:0]                duty;

    modport source (output valid, output speed_rpm, output duty, input ready);
    modport sink (input valid, input speed_rpm, input duty, output ready);
endinterface

### hw/rtl/esip_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel: register index and write data
// depends on esip_pkg
interface esip_cfg_if;
    import esip_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/encoder_speed_incremental_pid.sv
`timescale 1ns / 1ps
// Quadrature encoder speed meter with an incremental pid duty controller.
// An edge event is counted in the dispatch step, after which the next item can
// be accepted; a control tick runs on through the pid steps and produces one result item
// (speed and duty). The tick work is a nine-step microcode program that
// shares one 17 x 27 bit multiplier across the speed product and the three
// pid gain products. A tick stalls in its final step only while the previous
// result is still waiting in the output register. Configuration writes are
// taken in any cycle and should be made while no item is in flight.
// Depends on esip_pkg, esip_in_if, esip_out_if, esip_cfg_if, esip_seq, esip_datapath.
module encoder_speed_incremental_pid
    import esip_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    esip_in_if.sink  evt,
    esip_out_if.source res,
    esip_cfg_if.sink cfg
);

    cfg_t                      cfg_reg;
    ctrl_t                     ctrl;
    logic                      busy;
    logic                      start;
    logic                      is_tick;
    logic                      out_full;
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] out_speed_reg;
    logic [7:0]                out_duty_reg;
    logic signed [SPEED_W-1:0] dp_speed;
    logic [7:0]                dp_duty;

    assign evt.ready = !busy;
    assign start     = evt.valid && !busy;
    assign cfg.ready = 1'b1;
    assign out_full  = out_valid_reg && !res.ready;

    assign res.valid     = out_valid_reg;
    assign res.speed_rpm = out_speed_reg;
    assign res.duty      = out_duty_reg;

    esip_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .is_tick  (is_tick),
        .out_full (out_full),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    esip_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (evt.command),
        .level_a   (evt.level_a),
        .level_b   (evt.level_b),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .is_tick   (is_tick),
        .res_speed (dp_speed),
        .res_duty  (dp_duty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= SPEED_W'(76800);
            cfg_reg.kp     <= GAIN_W'(1024);
            cfg_reg.ki     <= GAIN_W'(512);
            cfg_reg.kd     <= GAIN_W'(1024);
            cfg_reg.scale  <= GAIN_W'(295);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TARGET: cfg_reg.target <= cfg.data[SPEED_W-1:0];
                    REG_KP:     cfg_reg.kp     <= cfg.data[GAIN_W-1:0];
                    REG_KI:     cfg_reg.ki     <= cfg.data[GAIN_W-1:0];
                    REG_KD:     cfg_reg.kd     <= cfg.data[GAIN_W-1:0];
                    REG_SCALE:  cfg_reg.scale  <= cfg.data[GAIN_W-1:0];
                    default:    ;
                endcase
            end
            if (ctrl.emit)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_speed_reg <= dp_speed;
            out_duty_reg  <= dp_duty;
        end
    end

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("item accepted without sequencer going busy");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> res.valid && res.speed_rpm == $past(dp_speed))
        else $error("emitted result not held in output register");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> !out_valid_reg || res.ready)
        else $error("result emitted over an undelivered one");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !ctrl.emit && ctrl.mul_sel == MUL_NONE && !ctrl.cnt_edge)
        else $error("datapath action while sequencer idle");
`endif

endmodule

### hw/rtl/esip_seq.sv
`timescale 1ns / 1ps
// microcode sequencer: step counter, rom fetch, branch and output stall
// depends on esip_pkg
module esip_seq
    import esip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  is_tick,
    input  logic  out_full,
    output ctrl_t ctrl,
    output logic  busy
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    ctrl_t           rom_w;
    logic            stall;
    logic            active;

    assign rom_w  = esip_rom(pc_reg);
    assign stall  = rom_w.emit && out_full;
    assign active = busy_reg && !stall;
    assign ctrl   = active ? rom_w : CTRL_NOP;
    assign busy   = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = STEP_DISPATCH;
            busy_next = 1'b1;
        end
        else if (active)
        begin
            unique case (rom_w.branch)
                BR_NEXT: pc_next = pc_reg + 1'b1;
                BR_TICK:
                begin
                    if (is_tick)
                        pc_next = rom_w.target;
                    else
                        busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_DISPATCH;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### hw/rtl/esip_datapath.sv
`timescale 1ns / 1ps
// datapath: edge counter, shared multiplier, error history, pid sum and duty clamp
// depends on esip_pkg, driven by control words from esip_seq
module esip_datapath
    import esip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                command,
    input  logic                      level_a,
    input  logic                      level_b,
    input  cfg_t                      cfg,
    input  ctrl_t                     ctrl,
    output logic                      is_tick,
    output logic signed [SPEED_W-1:0] res_speed,
    output logic [7:0]                res_duty
);

    localparam logic signed [COUNT_W-1:0] CNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] CNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]  SPD_HI  = PROD_W'(SPEED_MAX);
    localparam logic signed [PROD_W-1:0]  SPD_LO  = PROD_W'(SPEED_MIN);
    localparam logic signed [ACC_W-1:0]   ACC_TOP = ACC_W'(DUTY_TOP);

    logic [1:0]                cmd_reg;
    logic                      a_reg;
    logic                      b_reg;
    logic signed [COUNT_W-1:0] count_reg;
    logic signed [COUNT_W-1:0] count_next;
    logic signed [E_W-1:0]     last_e_reg;
    logic signed [DE_W-1:0]    last_de_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic [DUTY_W-1:0]         duty_next;

    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [E_W-1:0]     e_reg;
    logic signed [DE_W-1:0]    de_reg;
    logic signed [DDE_W-1:0]   dde_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    logic                      up;
    logic                      is_edge;
    logic [GAIN_W-1:0]         mul_gain;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [SPEED_W-1:0] speed_sat;
    logic signed [SUM_W-1:0]   sum_shift;
    logic signed [INC_W-1:0]   inc;
    logic signed [ACC_W-1:0]   acc_full;

    assign is_tick = (cmd_reg == CMD_TICK);
    assign is_edge = (cmd_reg == CMD_EDGE_A) || (cmd_reg == CMD_EDGE_B);
    assign up      = (cmd_reg == CMD_EDGE_A) ? (a_reg == b_reg) : (a_reg != b_reg);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.cnt_edge && is_edge)
        begin
            if (up && count_reg != CNT_MAX)
                count_next = count_reg + 1'b1;
            else if (!up && count_reg != CNT_MIN)
                count_next = count_reg - 1'b1;
        end
        else if (ctrl.ld_speed)
            count_next = '0;
    end

    always_comb
    begin
        mul_gain = cfg.scale;
        mul_b    = MUL_B_W'(count_reg);
        unique case (ctrl.mul_sel)
            MUL_KI:
            begin
                mul_gain = cfg.ki;
                mul_b    = MUL_B_W'(e_reg);
            end
            MUL_KP:
            begin
                mul_gain = cfg.kp;
                mul_b    = MUL_B_W'(de_reg);
            end
            MUL_KD:
            begin
                mul_gain = cfg.kd;
                mul_b    = MUL_B_W'(dde_reg);
            end
            default:
            begin
                mul_gain = cfg.scale;
                mul_b    = MUL_B_W'(count_reg);
            end
        endcase
    end

    assign prod_next = $signed({1'b0, mul_gain}) * mul_b;

    always_comb
    begin
        priority if (prod_reg > SPD_HI)
            speed_sat = SPEED_W'(SPEED_MAX);
        else if (prod_reg < SPD_LO)
            speed_sat = SPEED_W'(SPEED_MIN);
        else
            speed_sat = prod_reg[SPEED_W-1:0];
    end

    // floor shift of the pid sum, then clamp the accumulator
    assign sum_shift = sum_reg >>> FRAC_BITS;
    assign inc       = sum_shift[INC_W-1:0];
    assign acc_full  = $signed({{(ACC_W-DUTY_W){1'b0}}, duty_reg}) + ACC_W'(inc);

    always_comb
    begin
        priority if (acc_full < 0)
            duty_next = '0;
        else if (acc_full > ACC_TOP)
            duty_next = DUTY_W'(DUTY_TOP);
        else
            duty_next = acc_full[DUTY_W-1:0];
    end

    assign res_speed = speed_reg;
    assign res_duty  = duty_next[DUTY_W-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            last_e_reg  <= '0;
            last_de_reg <= '0;
            duty_reg    <= DUTY_W'(DUTY_RESET);
        end
        else
        begin
            count_reg <= count_next;
            if (ctrl.emit)
            begin
                last_e_reg  <= e_reg;
                last_de_reg <= de_reg;
                duty_reg    <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= command;
            a_reg   <= level_a;
            b_reg   <= level_b;
        end
        if (ctrl.mul_sel != MUL_NONE)
            prod_reg <= prod_next;
        if (ctrl.ld_speed)
            speed_reg <= speed_sat;
        if (ctrl.ld_e)
            e_reg <= E_W'(cfg.target) - E_W'(speed_reg);
        if (ctrl.ld_de)
            de_reg <= DE_W'(e_reg) - DE_W'(last_e_reg);
        if (ctrl.ld_dde)
            dde_reg <= DDE_W'(de_reg) - DDE_W'(last_de_reg);
        if (ctrl.sum_load)
            sum_reg <= SUM_W'(prod_reg);
        else if (ctrl.sum_add)
            sum_reg <= sum_reg + SUM_W'(prod_reg);
    end

endmodule
